// ===== sv/hfis_pkg.sv =====
// ----------------------------------------------------------------------------
// hfis_pkg: shared widths, types and coefficient table
// Sizes of the Hilbert I/Q splitter and the Blackman-windowed Hilbert
// coefficients, worked out at elaboration in signed Q1.(COEF_WIDTH-1).
// ----------------------------------------------------------------------------
package hfis_pkg;

    // filter size and word widths
    localparam int TAPS         = 31;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 18;
    localparam int HALF_LEN     = (TAPS - 1) / 2;

    // product and accumulator widths, sized so the sum never wraps
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    // output rounding: add half an lsb, then drop the fraction bits
    localparam int FRAC_BITS = COEF_WIDTH - 1;
    localparam int QW_W      = ACC_W + 1 - FRAC_BITS;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic [TAPS-1:0][COEF_WIDTH-1:0] coef_tab_t;

    // fixed point constants of the window and of the coefficient scale
    localparam longint          ONE_Q30         = 64'sd1 << 30;
    localparam longint unsigned TWO_PI_Q30      = 64'd6746518852;
    localparam longint unsigned TWO_OVER_PI_Q30 = 64'd683565276;
    localparam longint          W_A             = 64'sd450971566;
    localparam longint          W_C             = 64'sd85899346;
    localparam longint unsigned TAP_SPAN        = longint'(TAPS - 1);
    localparam longint unsigned TWO_SPAN        = 2 * TAP_SPAN;
    localparam int              COEF_SHIFT      = 61 - COEF_WIDTH;

    // divisors of the cosine series terms, (2i-1)*(2i)
    localparam longint unsigned FACT_DIV [1:9] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
    };

    // windowed hilbert coefficients, entry 0 weights the newest sample
    function automatic coef_tab_t build_coefs();
        coef_tab_t       tab;
        longint unsigned r;
        longint unsigned n2;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned quo;
        longint unsigned kmag;
        longint          sum;
        longint          cosv [2];
        longint          w;
        longint          wmag;
        longint          mag;
        bit              neg_c;
        bit              neg;
        int              k;
        tab = '0;
        for (int n = 0; n < TAPS; n++)
        begin
            k = n - HALF_LEN;
            if (k != 0 && k[0])
            begin
                // cosines of one and two turns-fractions, folded to a quarter turn
                for (int m = 0; m < 2; m++)
                begin
                    r = longint'((m + 1) * n) % TAP_SPAN;
                    if (2 * r > TAP_SPAN)
                        r = TAP_SPAN - r;
                    neg_c = 1'b0;
                    if (4 * r > TAP_SPAN)
                    begin
                        neg_c = 1'b1;
                        n2 = TAP_SPAN - 2 * r;
                    end
                    else
                    begin
                        n2 = 2 * r;
                    end
                    x    = (TWO_PI_Q30 * n2) / TWO_SPAN;
                    x2   = (x * x) >> 30;
                    term = longint'(ONE_Q30);
                    sum  = ONE_Q30;
                    for (int i = 1; i <= 9; i++)
                    begin
                        term = ((term * x2) >> 30) / FACT_DIV[i];
                        if (i % 2 == 1)
                            sum = sum - longint'(term);
                        else
                            sum = sum + longint'(term);
                    end
                    cosv[m] = neg_c ? -sum : sum;
                end
                // blackman window in q30
                w    = W_A - cosv[0] / 2 + (W_C * cosv[1]) / ONE_Q30;
                wmag = (w < 0) ? -w : w;
                kmag = longint'((k < 0) ? -k : k);
                neg  = (w < 0) != (k < 0);
                // long division of the scaled window by the tap offset
                num = longint'(wmag) * TWO_OVER_PI_Q30;
                rem = '0;
                quo = '0;
                for (int b = 63; b >= 0; b--)
                begin
                    rem = (rem << 1) | longint'(num[b]);
                    if (rem >= kmag)
                    begin
                        rem    = rem - kmag;
                        quo[b] = 1'b1;
                    end
                end
                mag = longint'((quo + (64'd1 << (COEF_SHIFT - 1))) >> COEF_SHIFT);
                tab[n] = COEF_WIDTH'(neg ? -mag : mag);
            end
        end
        return tab;
    endfunction

endpackage

// ===== sv/hfis_cell.sv =====
// ----------------------------------------------------------------------------
// hfis_cell: one tap of the transposed hilbert filter
// Adds its coefficient times the broadcast sample to the partial sum of the
// next cell, and passes the sample history one place down the row.
// ----------------------------------------------------------------------------
module hfis_cell
    import hfis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  coef_t   coef,
    input  sample_t sample_in,
    input  acc_t    sum_in,
    input  sample_t hist_in,
    output acc_t    sum_out,
    output sample_t hist_out
);

    acc_t    sum_reg;
    acc_t    sum_next;
    sample_t hist_reg;
    sample_t hist_next;
    prod_t   prod;

    // tap product and partial sum
    always_comb
    begin
        prod      = prod_t'(sample_in) * prod_t'(coef);
        sum_next  = shift ? (acc_t'(prod) + sum_in) : sum_reg;
        hist_next = shift ? hist_in : hist_reg;
    end

    // cell state, cleared to an all-zero history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            hist_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            hist_reg <= hist_next;
        end
    end

    assign sum_out  = sum_reg;
    assign hist_out = hist_reg;

endmodule

// ===== sv/hilbert_fir_iq_splitter.sv =====
// ----------------------------------------------------------------------------
// hilbert_fir_iq_splitter: real sample in, I/Q pair out
// Q is a Blackman-windowed Hilbert FIR built as a row of transposed-form
// cells; I is the input delayed by half the filter length.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+----------------------
//   sample   | sample_valid, sample_stall | sample_in
//   iq       | iq_valid, iq_stall         | i_out, q_out
//
// One sample word is taken per clock while the output side keeps up.
// A taken word passes through the cell row and then the rounding and
// saturation register on its way to the output.
// The cell row advances only when a word is taken, so the filter history
// holds through any stall; a stalled output stalls the input once the cell row holds a word.
// Reset clears the history to zeros and empties both stages.
// ----------------------------------------------------------------------------
module hilbert_fir_iq_splitter
    import hfis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample_in,
    output logic    iq_valid,
    input  logic    iq_stall,
    output sample_t i_out,
    output sample_t q_out
);

    localparam coef_tab_t COEFS = build_coefs();
    localparam acc_t      ROUND_HALF = acc_t'(64'sd1 << (COEF_WIDTH - 2));

    acc_t    sum_w  [TAPS+1];
    sample_t hist_w [TAPS+1];

    logic    acc_valid_reg;
    logic    acc_valid_next;
    logic    iq_valid_reg;
    logic    iq_valid_next;
    sample_t i_reg;
    sample_t q_reg;
    logic    out_free;
    logic    acc_free;
    logic    take;
    logic    move;

    logic signed [ACC_W:0]  rnd;
    logic signed [QW_W-1:0] qw;
    logic [QW_W-SAMPLE_WIDTH:0] q_top;
    sample_t                q_sat;

    // handshake between input, cell row and output register
    always_comb
    begin
        out_free       = !iq_valid_reg || !iq_stall;
        acc_free       = !acc_valid_reg || out_free;
        take           = sample_valid && acc_free;
        move           = acc_valid_reg && out_free;
        acc_valid_next = take ? 1'b1 : (move ? 1'b0 : acc_valid_reg);
        iq_valid_next  = out_free ? move : iq_valid_reg;
    end

    assign sample_stall = !acc_free;

    // row of filter cells
    assign sum_w[TAPS] = '0;
    assign hist_w[0]   = sample_in;

    for (genvar g = 0; g < TAPS; g++)
    begin : g_cell
        hfis_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (take),
            .coef      (coef_t'(COEFS[g])),
            .sample_in (sample_in),
            .sum_in    (sum_w[g+1]),
            .hist_in   (hist_w[g]),
            .sum_out   (sum_w[g]),
            .hist_out  (hist_w[g+1])
        );
    end

    // round half up and saturate the filter sum
    always_comb
    begin
        rnd   = {sum_w[0][ACC_W-1], sum_w[0]} + (ACC_W+1)'(ROUND_HALF);
        qw    = rnd[ACC_W:FRAC_BITS];
        q_top = qw[QW_W-1:SAMPLE_WIDTH-1];
        if ((&q_top) || !(|q_top))
            q_sat = qw[SAMPLE_WIDTH-1:0];
        else if (qw[QW_W-1])
            q_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            q_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            iq_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
            iq_valid_reg  <= iq_valid_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            i_reg <= hist_w[HALF_LEN+1];
            q_reg <= q_sat;
        end
    end

    assign iq_valid = iq_valid_reg;
    assign i_out    = i_reg;
    assign q_out    = q_reg;

endmodule
